// ===== src/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared widths, register indexes and the items that travel between the
// front end, the gradient queue and the magnitude pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W_W    = 12;
  localparam int CFG_H_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  // largest sizes the configuration registers can express
  localparam int CFG_W_MAX = (1 << CFG_W_W) - 1;
  localparam int CFG_H_MAX = (1 << CFG_H_W) - 1;

  localparam int ROW_OUT_W = 12;
  localparam int COL_OUT_W = 11;
  localparam int MAG_W     = 11;
  localparam int GRAD_W    = 10;
  localparam int SQ_W      = 21;
  localparam int DIM_W     = 14;
  localparam int SUM_W     = 12;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } res_meta_t;

  typedef struct packed {
    logic [GRAD_W-1:0] ax;
    logic [GRAD_W-1:0] ay;
    res_meta_t         meta;
  } grad_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== src/sgm_ram.sv =====
// ----------------------------------------------------------------------------
// sgm_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/sgm_front.sv =====
// ----------------------------------------------------------------------------
// sgm_front
// Size registers, raster counters, line stores and 3x3 window. Classifies
// each pixel as interior or border and pushes the absolute Sobel sums of
// interior centres into the gradient queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_front #(
  parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sgm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sgm_pkg::PIX_W-1:0]     pixel_value,
  input  wire sgm_pkg::fifo_stat_t           q_stat,
  output logic                               push,
  output sgm_pkg::grad_item_t                push_item
);

  import sgm_pkg::*;

  localparam int EFF_MAX_W = (MAX_WIDTH < CFG_W_MAX) ? MAX_WIDTH : CFG_W_MAX;
  localparam int EFF_MAX_H = (MAX_HEIGHT < CFG_H_MAX) ? MAX_HEIGHT : CFG_H_MAX;
  localparam int COL_W     = $clog2(EFF_MAX_W);
  localparam int ROW_W     = $clog2(EFF_MAX_H);

  logic [CFG_W_W-1:0] image_width;
  logic [CFG_H_W-1:0] image_height;
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;

  logic [COL_W-1:0] col_cnt;
  logic [COL_W-1:0] col_cnt_next;
  logic [ROW_W-1:0] row_cnt;
  logic [ROW_W-1:0] row_cnt_next;

  logic [DIM_W-1:0] c0, r0, c1, r1, r_inc;
  logic             accept;
  logic             emit_now;
  logic             last_now;

  // stage a: pixel waiting for its line store reads
  logic             a_valid;
  logic [PIX_W-1:0] a_p;
  logic [COL_W-1:0] a_c;
  logic [ROW_W-1:0] a_r;
  logic             a_emit;
  logic             a_last;

  logic             b_go;
  logic             b_fire;

  logic [PIX_W-1:0] rd_up, rd_mid;
  logic [PIX_W-1:0] up, mid;
  logic             fwd_hit;
  logic [PIX_W-1:0] fwd_up, fwd_mid;

  logic [PIX_W-1:0] win [6];

  logic [SUM_W-1:0] pos_x, neg_x, pos_y, neg_y, dx, dy, abs_x, abs_y;
  logic [DIM_W-1:0] row_m1, col_m1;

  // configuration, taken on cfg_valid; the user must write it only while idle, and the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W_W'(RESET_WIDTH);
      image_height <= CFG_H_W'(RESET_HEIGHT);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_W_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_W'(image_height);
    end
  end

  assign b_go     = !q_stat.full;
  assign b_fire   = a_valid && b_go;
  assign in_ready = !a_valid || b_go;
  assign accept   = in_valid && in_ready;

  // position of the incoming pixel, wrapping counters left beyond a new size
  always_comb begin
    c0 = DIM_W'(col_cnt);
    r0 = DIM_W'(row_cnt);
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + DIM_W'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    if (r1 >= h_eff) begin
      r1 = '0;
    end
    r_inc    = r1 + DIM_W'(1);
    emit_now = (r1 >= DIM_W'(2)) && (c1 >= DIM_W'(2));
    last_now = (r_inc == h_eff) && ((c1 + DIM_W'(1)) == w_eff);
    if ((c1 + DIM_W'(1)) >= w_eff) begin
      col_cnt_next = '0;
      row_cnt_next = (r_inc >= h_eff) ? '0 : ROW_W'(r_inc);
    end else begin
      col_cnt_next = COL_W'(c1 + DIM_W'(1));
      row_cnt_next = ROW_W'(r1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      a_valid <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt <= col_cnt_next;
        row_cnt <= row_cnt_next;
        a_valid <= 1'b1;
      end else if (b_go) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_p    <= pixel_value;
      a_c    <= COL_W'(c1);
      a_r    <= ROW_W'(r1);
      a_emit <= emit_now;
      a_last <= last_now;
    end
  end

  // a read issued on the same edge as a write to that column sees old data
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= b_fire && (COL_W'(c1) == a_c);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_up  <= mid;
      fwd_mid <= a_p;
    end
  end

  sgm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (EFF_MAX_W)
  ) u_line_upper (
    .clk   (clk),
    .we    (b_fire),
    .waddr (a_c),
    .wdata (mid),
    .re    (accept),
    .raddr (COL_W'(c1)),
    .rdata (rd_up)
  );

  sgm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (EFF_MAX_W)
  ) u_line_middle (
    .clk   (clk),
    .we    (b_fire),
    .waddr (a_c),
    .wdata (a_p),
    .re    (accept),
    .raddr (COL_W'(c1)),
    .rdata (rd_mid)
  );

  assign up  = fwd_hit ? fwd_up  : rd_up;
  assign mid = fwd_hit ? fwd_mid : rd_mid;

  // window: 0..2 two columns back (top, mid, bottom), 3..5 one column back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (b_fire) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= up;
      win[4] <= mid;
      win[5] <= a_p;
    end
  end

  always_comb begin
    pos_x = SUM_W'(up) + (SUM_W'(mid) << 1) + SUM_W'(a_p);
    neg_x = SUM_W'(win[0]) + (SUM_W'(win[1]) << 1) + SUM_W'(win[2]);
    pos_y = SUM_W'(win[2]) + (SUM_W'(win[5]) << 1) + SUM_W'(a_p);
    neg_y = SUM_W'(win[0]) + (SUM_W'(win[3]) << 1) + SUM_W'(up);
    dx    = pos_x - neg_x;
    dy    = pos_y - neg_y;
    abs_x = dx[SUM_W-1] ? (SUM_W'(0) - dx) : dx;
    abs_y = dy[SUM_W-1] ? (SUM_W'(0) - dy) : dy;
    row_m1 = DIM_W'(a_r) - DIM_W'(1);
    col_m1 = DIM_W'(a_c) - DIM_W'(1);
  end

  assign push           = b_fire && a_emit;
  assign push_item.ax   = abs_x[GRAD_W-1:0];
  assign push_item.ay   = abs_y[GRAD_W-1:0];
  assign push_item.meta.row  = row_m1[ROW_OUT_W-1:0];
  assign push_item.meta.col  = col_m1[COL_OUT_W-1:0];
  assign push_item.meta.last = a_last;

endmodule

`default_nettype wire

// ===== src/sgm_queue.sv =====
// ----------------------------------------------------------------------------
// sgm_queue
// Short register queue of gradient items between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_queue #(
  parameter int DEPTH = sgm_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire sgm_pkg::grad_item_t push_item,
  input  wire logic                pop,
  output sgm_pkg::grad_item_t      pop_item,
  output sgm_pkg::fifo_stat_t      stat
);

  import sgm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  grad_item_t       entry [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= ptr_inc(tail);
      end
      if (pop) begin
        head <= ptr_inc(head);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[tail] <= push_item;
    end
  end

  assign pop_item   = entry[head];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

// ===== src/sgm_back.sv =====
// ----------------------------------------------------------------------------
// sgm_back
// Squares the Sobel sums and takes the floor square root one result bit
// per pipeline stage; the last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sgm_pkg::fifo_stat_t           q_stat,
  input  wire sgm_pkg::grad_item_t           pop_item,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sgm_pkg::ROW_OUT_W-1:0]      center_row,
  output logic [sgm_pkg::COL_OUT_W-1:0]      center_col,
  output logic [sgm_pkg::MAG_W-1:0]          magnitude,
  output logic                               frame_last
);

  import sgm_pkg::*;

  localparam int ST   = MAG_W;
  localparam int TR_W = 2 * MAG_W + 1;
  localparam int P_W  = 2 * GRAD_W;

  logic en;

  logic            s_vld;
  logic [P_W-1:0]  s_ax2;
  logic [P_W-1:0]  s_ay2;
  res_meta_t       s_meta;

  logic            vld  [ST+1];
  logic [SQ_W-1:0] rem  [ST+1];
  logic [MAG_W-1:0] root [ST+1];
  res_meta_t       meta [ST+1];

  // whole pipeline holds while a result waits at the output
  assign en  = !vld[ST] || out_ready;
  assign pop = en && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld  <= 1'b0;
      vld[0] <= 1'b0;
    end else if (en) begin
      s_vld  <= pop;
      vld[0] <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_ax2   <= P_W'(pop_item.ax) * P_W'(pop_item.ax);
      s_ay2   <= P_W'(pop_item.ay) * P_W'(pop_item.ay);
      s_meta  <= pop_item.meta;
      rem[0]  <= SQ_W'(s_ax2) + SQ_W'(s_ay2);
      root[0] <= '0;
      meta[0] <= s_meta;
    end
  end

  for (genvar k = 0; k < ST; k++) begin : g_root
    localparam int B = ST - 1 - k;
    logic [TR_W-1:0] trial;
    logic [TR_W-1:0] rem_ext;
    logic            take;

    // try setting result bit B: needs rem >= (root << (B+1)) + 4^B
    assign trial   = (TR_W'(root[k]) << (B + 1)) | (TR_W'(1) << (2 * B));
    assign rem_ext = TR_W'(rem[k]);
    assign take    = rem_ext >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? SQ_W'(rem_ext - trial) : rem[k];
        root[k+1] <= take ? (root[k] | (MAG_W'(1) << B)) : root[k];
        meta[k+1] <= meta[k];
      end
    end
  end

  assign out_valid  = vld[ST];
  assign magnitude  = root[ST];
  assign center_row = meta[ST].row;
  assign center_col = meta[ST].col;
  assign frame_last = meta[ST].last;

endmodule

`default_nettype wire

// ===== src/sobel_gradient_magnitude.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// 3x3 Sobel gradient magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and keeps that rate for as long as results are
// taken; in_ready falls only when the four-beat gradient queue is full because
// the output is stalled. After its pixel is accepted, a result for an interior
// centre passes through one front stage (line store read, with the window and
// Sobel sums formed behind it), the queue, a squaring stage, a sum stage and
// eleven square root stages that settle one result bit each. Border centres
// give no beat. The line stores are not cleared after reset; the first two
// rows of a frame fill them. image_width and image_height may be written
// only while no pixel is in flight, and cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sgm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [sgm_pkg::PIX_W-1:0]      pixel_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [sgm_pkg::ROW_OUT_W-1:0]       center_row,
  output logic [sgm_pkg::COL_OUT_W-1:0]       center_col,
  output logic [sgm_pkg::MAG_W-1:0]           magnitude,
  output logic                                frame_last
);

  import sgm_pkg::*;

  logic       q_push;
  logic       q_pop;
  grad_item_t q_in;
  grad_item_t q_out;
  fifo_stat_t q_stat;

  assign cfg_ready = 1'b1;

  sgm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_value (pixel_value),
    .q_stat      (q_stat),
    .push        (q_push),
    .push_item   (q_in)
  );

  sgm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .stat      (q_stat)
  );

  sgm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .pop_item   (q_out),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .center_row (center_row),
    .center_col (center_col),
    .magnitude  (magnitude),
    .frame_last (frame_last)
  );

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("gradient queue overflow");

  // the back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_stat.empty))
    else $error("gradient queue underflow");

  // input back-pressure comes only from a full queue
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_stat.full)
    else $error("in_ready low with room in the queue");

  // 8-bit pixels bound the magnitude
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (magnitude <= MAG_W'(1442)))
    else $error("magnitude out of range");

endmodule

`default_nettype wire
